// ----- sv/mlgm_pkg.sv -----
// ----------------------------------------------------------------------------
// mlgm_pkg
// shared types, constants and codes for the low-pass gain mixer
// ----------------------------------------------------------------------------
package mlgm_pkg;

  // channels that carry real filter state
  localparam int CHANNEL_COUNT = 4;
  // slots addressed by the channel field
  localparam int CH_W     = 2;
  localparam int NUM_SLOTS = 1 << CH_W;

  localparam int SAMPLE_W = 16;
  localparam int ALPHA_W  = 17;
  localparam int GAIN_W   = 24;
  localparam int FILT_W   = 32;
  localparam int ACC_W    = 48;
  localparam int PROD_W   = FILT_W + GAIN_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [ALPHA_W-1:0]  ONE_ALPHA = ALPHA_W'(65536);
  localparam logic [GAIN_W-1:0]   ONE_GAIN  = GAIN_W'(65536);
  localparam logic [SAMPLE_W-1:0] SUM_MAX   = SAMPLE_W'(65535);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA_CH0 = 3'd0,
    REG_ALPHA_CH1 = 3'd1,
    REG_ALPHA_CH2 = 3'd2,
    REG_ALPHA_CH3 = 3'd3,
    REG_GAIN_CH0  = 3'd4,
    REG_GAIN_CH1  = 3'd5,
    REG_GAIN_CH2  = 3'd6,
    REG_GAIN_CH3  = 3'd7
  } mlgm_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_AX,
    ST_MUL_BP,
    ST_FILT,
    ST_MUL_G,
    ST_ACC,
    ST_EMIT
  } mlgm_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul_ax;
    logic mul_bp;
    logic filt;
    logic mul_g;
    logic acc;
    logic emit;
  } mlgm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_active;
    logic in_started;
    logic in_last;
    logic last;
    logic out_free;
  } mlgm_sts_t;

endpackage

// ----- sv/mlgm_if.sv -----
// ----------------------------------------------------------------------------
// mlgm_if
// valid/ready channels for sample beats and mixed result beats
// ----------------------------------------------------------------------------
interface mlgm_in_if import mlgm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     channel;
  logic [SAMPLE_W-1:0] sample_value;
  logic                sample_present;
  logic                round_end;

  modport source (output valid, channel, sample_value, sample_present, round_end,
                  input ready);
  modport sink (input valid, channel, sample_value, sample_present, round_end,
                output ready);
endinterface

interface mlgm_out_if import mlgm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] mixed_sum;
  logic                saturated;

  modport source (output valid, mixed_sum, saturated, input ready);
  modport sink (input valid, mixed_sum, saturated, output ready);
endinterface

// ----- sv/mlgm_ctrl.sv -----
// ----------------------------------------------------------------------------
// mlgm_ctrl
// sequencer for the shared multiplier: filter, gain, accumulate, emit
// ----------------------------------------------------------------------------
module mlgm_ctrl import mlgm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mlgm_sts_t sts,
  output mlgm_cmd_t cmd
);

  mlgm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.in_active && sts.in_started) begin
            state_nxt = ST_MUL_AX;
          end else if (sts.in_active) begin
            state_nxt = ST_FILT;
          end else if (sts.in_last) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_MUL_AX: begin
        cmd.mul_ax = 1'b1;
        state_nxt  = ST_MUL_BP;
      end
      ST_MUL_BP: begin
        cmd.mul_bp = 1'b1;
        state_nxt  = ST_FILT;
      end
      ST_FILT: begin
        cmd.filt  = 1'b1;
        state_nxt = ST_MUL_G;
      end
      ST_MUL_G: begin
        cmd.mul_g = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // hold until the result register is free
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/mlgm_dp.sv -----
// ----------------------------------------------------------------------------
// mlgm_dp
// settings, filter state, shared multiplier, accumulator and result register
// ----------------------------------------------------------------------------
module mlgm_dp import mlgm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CH_W-1:0]       in_channel,
  input  logic [SAMPLE_W-1:0]   in_sample_value,
  input  logic                  in_sample_present,
  input  logic                  in_round_end,
  input  mlgm_cmd_t             cmd,
  output mlgm_sts_t             sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_mixed_sum,
  output logic                  out_saturated
);

  logic [ALPHA_W-1:0]  alpha_r   [NUM_SLOTS];
  logic [GAIN_W-1:0]   gain_r    [NUM_SLOTS];
  logic [FILT_W-1:0]   filt_r    [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] started_r;

  logic [CH_W-1:0]     ch_r;
  logic [SAMPLE_W-1:0] x_r;
  logic                last_r;
  logic                first_r;
  logic [PROD_W-1:0]   prod_r;
  logic [FILT_W-1:0]   ax_r;
  logic [ACC_W-1:0]    acc_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] sum_r;
  logic                sat_r;

  logic [ALPHA_W-1:0]  alpha_eff;
  logic [ALPHA_W-1:0]  beta_eff;
  logic [GAIN_W-1:0]   gain_eff;
  logic [FILT_W-1:0]   mul_a;
  logic [GAIN_W-1:0]   mul_b;
  logic [FILT_W-1:0]   y_new;
  logic [ACC_W:0]      ceil_full;
  logic [ACC_W-16:0]   ceil_sum;
  logic                ceil_sat;

  // settings, clamped as they are used
  always_comb begin
    alpha_eff = (alpha_r[ch_r] > ONE_ALPHA) ? ONE_ALPHA : alpha_r[ch_r];
    beta_eff  = ONE_ALPHA - alpha_eff;
    gain_eff  = (gain_r[ch_r] == '0) ? ONE_GAIN : gain_r[ch_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        alpha_r[i] <= ONE_ALPHA;
        gain_r[i]  <= ONE_GAIN;
      end
    end else if (cfg_we) begin
      case (mlgm_reg_t'(cfg_index))
        REG_ALPHA_CH0: alpha_r[0] <= cfg_data[ALPHA_W-1:0];
        REG_ALPHA_CH1: alpha_r[1] <= cfg_data[ALPHA_W-1:0];
        REG_ALPHA_CH2: alpha_r[2] <= cfg_data[ALPHA_W-1:0];
        REG_ALPHA_CH3: alpha_r[3] <= cfg_data[ALPHA_W-1:0];
        REG_GAIN_CH0:  gain_r[0]  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_CH1:  gain_r[1]  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_CH2:  gain_r[2]  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_CH3:  gain_r[3]  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // status for the controller
  always_comb begin
    sts.in_active  = in_sample_present &&
                     ({1'b0, in_channel} < (CH_W+1)'(CHANNEL_COUNT));
    sts.in_started = started_r[in_channel];
    sts.in_last    = in_round_end;
    sts.last       = last_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r    <= in_channel;
      x_r     <= in_sample_value;
      last_r  <= in_round_end;
      first_r <= !started_r[in_channel];
    end
  end

  // shared 32x24 multiplier operand select
  always_comb begin
    mul_a = filt_r[ch_r];
    mul_b = gain_eff;
    if (cmd.mul_ax) begin
      mul_a = FILT_W'(x_r);
      mul_b = GAIN_W'(alpha_eff);
    end else if (cmd.mul_bp) begin
      mul_b = GAIN_W'(beta_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_ax || cmd.mul_bp || cmd.mul_g) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.mul_bp) begin
      // alpha*x is below 2^32
      ax_r <= prod_r[FILT_W-1:0];
    end
  end

  // first sample passes through, else alpha*x + floor(beta*prev / 2^16)
  assign y_new = first_r ? {x_r, 16'h0000}
                         : FILT_W'(ax_r + FILT_W'(prod_r[PROD_W-1:16]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        filt_r[i] <= '0;
      end
    end else if (cmd.filt) begin
      filt_r[ch_r]    <= y_new;
      started_r[ch_r] <= 1'b1;
    end
  end

  // ceiling of the Q.16 sum, saturated
  always_comb begin
    ceil_full = (ACC_W+1)'(acc_r) + (ACC_W+1)'(17'h0FFFF);
    ceil_sum  = ceil_full[ACC_W:16];
    ceil_sat  = |ceil_sum[ACC_W-16:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.acc) begin
      acc_r <= ACC_W'(acc_r + ACC_W'(prod_r[PROD_W-1:16]));
    end else if (cmd.emit) begin
      acc_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sum_r <= ceil_sat ? SUM_MAX : ceil_sum[SAMPLE_W-1:0];
      sat_r <= ceil_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_mixed_sum = sum_r;
  assign out_saturated = sat_r;

endmodule

// ----- sv/multichannel_lowpass_gain_mixer.sv -----
// ----------------------------------------------------------------------------
// multichannel_lowpass_gain_mixer
// per-channel exponential low-pass, gain and round mixer with saturated output
// ----------------------------------------------------------------------------
// steps: an absent or out-of-range beat ends in ST_IDLE, a channel's first
//   sample runs ST_FILT, ST_MUL_G, ST_ACC, a filtered one ST_MUL_AX, ST_MUL_BP
//   first; a round-end beat adds ST_EMIT, held while the result reg is full;
//   one shared 32x24 multiplier does alpha*x, (1-alpha)*prev and the gain product
//   in turn, each registered; result beat valid the cycle after the emit step
// reset: rst_n synchronous active low; settings go to 1.0, filter state,
//   started flags and the accumulator clear, result register empties
// ----------------------------------------------------------------------------
module multichannel_lowpass_gain_mixer import mlgm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // sample beats
  mlgm_in_if.sink               in_ch,
  // mixed result beats
  mlgm_out_if.source            out_ch
);

  mlgm_cmd_t cmd;
  mlgm_sts_t sts;
  logic      in_ready;

  // sequencer: one beat at a time through the multiplier steps
  mlgm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // settings, filter state, multiplier, accumulator and result register
  mlgm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_channel        (in_ch.channel),
    .in_sample_value   (in_ch.sample_value),
    .in_sample_present (in_ch.sample_present),
    .in_round_end      (in_ch.round_end),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_mixed_sum     (out_ch.mixed_sum),
    .out_saturated     (out_ch.saturated)
  );

endmodule
